// ===== hw/rtl/qmi_pkg.sv =====
`default_nettype none

package qmi_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam int unsigned KIND_POP_BIT = 1;

  typedef enum logic [1:0] {
    STATUS_PUSHED = 2'd0,
    STATUS_POPPED = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic        [1:0]        kind;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic        [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic exec;
    logic finish;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/queue_with_middle_insert_unit.sv =====
`default_nettype none

// Queue of up to CAPACITY signed 32-bit values with push at the tail, insert
// at the middle (position ceil(count/2)) and pop at the front, kept as two
// ring-buffer halves of (CAPACITY+1)/2 words each. A transaction is taken when
// start is high and busy is low; busy then stays high for one cycle and every
// transaction gives exactly one result, shown for that single cycle with
// done_o high, in the cycle right after the one in which start was taken. The
// result cannot be held off, so it must be captured in the cycle done_o is
// high. A new transaction is not taken while busy is high: when one is taken,
// the pointers are updated and both half memories are read, and in the finish
// state the item moved from the back half to the front half is written when
// rebalancing is needed. A pop on an empty queue returns 0 with an empty
// status; a push or insert on a full queue is dropped with a full status. No
// clearing pass is needed after reset.
module queue_with_middle_insert_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire qmi_pkg::req_t req_i,
  output logic               done_o,
  output qmi_pkg::rsp_t      rsp_o
);

  qmi_pkg::ctrl_cmd_t cmd;

  qmi_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_o (cmd)
  );

  qmi_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .rsp_o (rsp_o)
  );

  assign done_o = cmd.finish;

endmodule

`default_nettype wire

// ===== hw/rtl/qmi_ram.sv =====
`default_nettype none

module qmi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/qmi_ctrl.sv =====
`default_nettype none

module qmi_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  output qmi_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start && !busy_q) begin
            state_q <= S_FIN;
            busy_q  <= 1'b1;
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy         = busy_q;
  assign cmd_o.exec   = start && !busy_q;
  assign cmd_o.finish = (state_q == S_FIN);

endmodule

`default_nettype wire

// ===== hw/rtl/qmi_datapath.sv =====
`default_nettype none

module qmi_datapath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qmi_pkg::ctrl_cmd_t cmd_i,
  input  wire qmi_pkg::req_t      req_i,
  output qmi_pkg::rsp_t           rsp_o
);

  localparam int unsigned HALF = (CAPACITY + 1) / 2;
  localparam int unsigned AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned CW   = $clog2(HALF + 1);
  localparam int unsigned TW   = $clog2(CAPACITY + 1);
  localparam int unsigned DW   = qmi_pkg::DATA_W;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] h);
    return (h == AW'(HALF - 1)) ? '0 : h + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] h);
    return (h == '0) ? AW'(HALF - 1) : h - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(HALF)) begin
      s = s - (CW+1)'(HALF);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CW-1:0] fc_q, fc_d, bc_q, bc_d;
  logic          move_q, move_d;
  logic          pop_ok_q, pop_ok_d;
  logic [1:0]    status_q, status_d;
  logic [AW-1:0] mwaddr_q, mwaddr_d;

  logic [TW-1:0] total;
  logic          front_app;
  logic          back_wr;
  logic [AW-1:0] back_waddr;

  logic          front_we;
  logic [AW-1:0] front_waddr;
  logic [DW-1:0] front_wdata;
  logic [DW-1:0] front_rdata;
  logic [DW-1:0] back_rdata;

  assign total    = TW'(fc_q) + TW'(bc_q);
  assign mwaddr_d = ring_add(fh_q, fc_q);

  always_comb begin
    fh_d       = fh_q;
    fc_d       = fc_q;
    bh_d       = bh_q;
    bc_d       = bc_q;
    move_d     = 1'b0;
    pop_ok_d   = 1'b0;
    front_app  = 1'b0;
    back_wr    = 1'b0;
    back_waddr = ring_add(bh_q, bc_q);
    status_d   = qmi_pkg::STATUS_PUSHED;
    if (req_i.kind[qmi_pkg::KIND_POP_BIT]) begin
      if (fc_q == '0) begin
        status_d = qmi_pkg::STATUS_EMPTY;
      end else begin
        status_d = qmi_pkg::STATUS_POPPED;
        pop_ok_d = 1'b1;
        fh_d     = ring_inc(fh_q);
        if (fc_q == bc_q) begin
          move_d = 1'b1;
          bh_d   = ring_inc(bh_q);
          bc_d   = bc_q - CW'(1);
        end else begin
          fc_d = fc_q - CW'(1);
        end
      end
    end else if (total >= TW'(CAPACITY)) begin
      status_d = qmi_pkg::STATUS_FULL;
    end else if (req_i.kind == qmi_pkg::KIND_PUSH) begin
      if (total == '0) begin
        front_app = 1'b1;
        fc_d      = fc_q + CW'(1);
      end else begin
        back_wr = 1'b1;
        if (bc_q == fc_q) begin
          move_d = 1'b1;
          bh_d   = ring_inc(bh_q);
          fc_d   = fc_q + CW'(1);
        end else begin
          bc_d = bc_q + CW'(1);
        end
      end
    end else begin
      if (TW'(fc_q) == (total >> 1)) begin
        front_app = 1'b1;
        fc_d      = fc_q + CW'(1);
      end else begin
        back_wr    = 1'b1;
        back_waddr = ring_dec(bh_q);
        bh_d       = ring_dec(bh_q);
        bc_d       = bc_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q     <= '0;
      fc_q     <= '0;
      bh_q     <= '0;
      bc_q     <= '0;
      move_q   <= 1'b0;
      pop_ok_q <= 1'b0;
      status_q <= qmi_pkg::STATUS_PUSHED;
    end else if (cmd_i.exec) begin
      fh_q     <= fh_d;
      fc_q     <= fc_d;
      bh_q     <= bh_d;
      bc_q     <= bc_d;
      move_q   <= move_d;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      mwaddr_q <= mwaddr_d;
    end
  end

  assign front_we    = (cmd_i.exec && front_app) || (cmd_i.finish && move_q);
  assign front_waddr = cmd_i.finish ? mwaddr_q : ring_add(fh_q, fc_q);
  assign front_wdata = cmd_i.finish ? back_rdata : DW'(req_i.item_value);

  qmi_ram #(
    .WIDTH(DW),
    .DEPTH(HALF)
  ) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (front_we),
    .waddr_i(front_waddr),
    .wdata_i(front_wdata),
    .re_i   (cmd_i.exec),
    .raddr_i(fh_q),
    .rdata_o(front_rdata)
  );

  qmi_ram #(
    .WIDTH(DW),
    .DEPTH(HALF)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && back_wr),
    .waddr_i(back_waddr),
    .wdata_i(DW'(req_i.item_value)),
    .re_i   (cmd_i.exec),
    .raddr_i(bh_q),
    .rdata_o(back_rdata)
  );

  assign rsp_o.popped_value = pop_ok_q ? front_rdata : '0;
  assign rsp_o.status       = status_q;

endmodule

`default_nettype wire
